### rtl/core/fbst_pkg.sv
// Shared types and constants for the frame buffer slot table.
`timescale 1ns / 1ps

package fbst_pkg;

    localparam int SLOTS       = 16;
    localparam int MAX_PAYLOAD = 1518;
    localparam int IDX_W       = $clog2(SLOTS);
    localparam int CNT_W       = (SLOTS > 2) ? $clog2(SLOTS - 1) : 1;

    localparam logic [15:0] ETYPE_ECAT = 16'h88A4;
    localparam logic [10:0] HDR_LEN    = 11'd14;
    localparam logic [10:0] MIN_FRAME  = 11'd60;
    localparam int          MAX_RXLEN  = MAX_PAYLOAD + 14;

    localparam logic [2:0] OP_ALLOC = 3'd0;
    localparam logic [2:0] OP_SET   = 3'd1;
    localparam logic [2:0] OP_TX    = 3'd2;
    localparam logic [2:0] OP_RX    = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;

    localparam logic [2:0] ST_EMPTY = 3'd0;
    localparam logic [2:0] ST_ALLOC = 3'd1;
    localparam logic [2:0] ST_TX    = 3'd2;
    localparam logic [2:0] ST_RCVD  = 3'd3;

    typedef struct packed {
        logic [2:0]  op;
        logic [3:0]  slot;
        logic [2:0]  new_status;
        logic [10:0] tx_length;
        logic [10:0] rx_length;
        logic [15:0] rx_ethertype;
        logic [7:0]  rx_slot_byte;
    } fbst_in_t;

    typedef struct packed {
        logic [3:0]  alloc_slot;
        logic [2:0]  slot_state;
        logic        sent;
        logic [10:0] padded_length;
        logic        frame_taken;
    } fbst_out_t;

    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [2:0]       wr_data;
    } fbst_ram_req_t;

endpackage

### rtl/core/fbst_status_ram.sv
// Slot status memory with per-entry valid bits and a registered read port.
`timescale 1ns / 1ps

module fbst_status_ram
    import fbst_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  fbst_ram_req_t req,
    output logic [2:0]    rd_data
);

    logic [2:0]       mem [SLOTS];
    logic [SLOTS-1:0] valid_reg;
    logic [2:0]       rd_mem_reg;
    logic             rd_valid_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_mem_reg <= mem[req.rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (req.wr_en) begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_mem_reg : ST_EMPTY;

endmodule

### rtl/core/fbst_seq.sv
// Operation sequencer: one memory access and one status compare per step.
`timescale 1ns / 1ps

module fbst_seq
    import fbst_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          item_valid,
    output logic          item_ready,
    input  fbst_in_t      item,
    input  logic          port_open,
    output fbst_ram_req_t ram_req,
    input  logic [2:0]    ram_rd_data,
    output logic          res_valid,
    input  logic          res_ready,
    output fbst_out_t     res
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ISSUE = 2'd1;
    localparam logic [1:0] S_EVAL  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    fbst_in_t         item_reg, item_next;
    fbst_out_t        res_reg, res_next;
    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] last_reg, last_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             phase_reg, phase_next;
    logic [2:0]       waited_reg, waited_next;

    logic             slot_ok;
    logic             frame_ok;
    logic [2:0]       waited_st;
    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] rsl_idx;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] r;
        if (int'(p) >= SLOTS - 1) begin
            r = IDX_W'(1);
        end else begin
            r = p + IDX_W'(1);
        end
        return r;
    endfunction

    assign slot_idx  = IDX_W'(item_reg.slot);
    assign rsl_idx   = IDX_W'(item_reg.rx_slot_byte);
    assign slot_ok   = int'(item_reg.slot) < SLOTS;
    assign waited_st = slot_ok ? ram_rd_data : ST_EMPTY;
    assign frame_ok  = (item_reg.rx_length > HDR_LEN)
                    && (int'(item_reg.rx_length) <= MAX_RXLEN)
                    && (item_reg.rx_ethertype == ETYPE_ECAT)
                    && (item_reg.rx_slot_byte != 8'd0)
                    && (int'(item_reg.rx_slot_byte) < SLOTS);

    always_comb begin
        state_next  = state_reg;
        item_next   = item_reg;
        res_next    = res_reg;
        ptr_next    = ptr_reg;
        last_next   = last_reg;
        cnt_next    = cnt_reg;
        phase_next  = phase_reg;
        waited_next = waited_reg;

        ram_req.rd_addr = slot_idx;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = slot_idx;
        ram_req.wr_data = ST_EMPTY;

        case (state_reg)
            S_IDLE: begin
                if (item_valid) begin
                    item_next  = item;
                    ptr_next   = wrap_inc(last_reg);
                    cnt_next   = '0;
                    phase_next = 1'b0;
                    res_next   = '0;
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (item_reg.op == OP_ALLOC) begin
                    ram_req.rd_addr = ptr_reg;
                end else if (phase_reg) begin
                    ram_req.rd_addr = rsl_idx;
                end
                state_next = S_EVAL;
            end
            S_EVAL: begin
                state_next = S_DONE;
                case (item_reg.op)
                    OP_ALLOC: begin
                        if (ram_rd_data == ST_EMPTY) begin
                            ram_req.wr_en       = 1'b1;
                            ram_req.wr_addr     = ptr_reg;
                            ram_req.wr_data     = ST_ALLOC;
                            last_next           = ptr_reg;
                            res_next.alloc_slot = 4'(ptr_reg);
                            res_next.slot_state = ST_ALLOC;
                        end else if (cnt_reg != CNT_W'(SLOTS - 2)) begin
                            cnt_next   = cnt_reg + CNT_W'(1);
                            ptr_next   = wrap_inc(ptr_reg);
                            state_next = S_ISSUE;
                        end
                    end
                    OP_SET: begin
                        ram_req.wr_en       = slot_ok;
                        ram_req.wr_data     = item_reg.new_status;
                        res_next.slot_state = slot_ok ? item_reg.new_status : ST_EMPTY;
                    end
                    OP_TX: begin
                        ram_req.wr_en       = slot_ok;
                        ram_req.wr_data     = ST_TX;
                        res_next.slot_state = slot_ok ? ST_TX : ST_EMPTY;
                        if ((item_reg.tx_length != 11'd0) && port_open) begin
                            res_next.sent          = 1'b1;
                            res_next.padded_length = (item_reg.tx_length < MIN_FRAME)
                                                   ? MIN_FRAME : item_reg.tx_length;
                        end
                    end
                    OP_RX: begin
                        if (!phase_reg) begin
                            waited_next         = waited_st;
                            res_next.slot_state = waited_st;
                            if ((waited_st != ST_RCVD) && (item_reg.rx_length != 11'd0)) begin
                                res_next.frame_taken = 1'b1;
                                if (frame_ok) begin
                                    phase_next = 1'b1;
                                    state_next = S_ISSUE;
                                end
                            end
                        end else if ((ram_rd_data == ST_TX) || (ram_rd_data == ST_ALLOC)) begin
                            ram_req.wr_en       = 1'b1;
                            ram_req.wr_addr     = rsl_idx;
                            ram_req.wr_data     = ST_RCVD;
                            res_next.slot_state = (item_reg.rx_slot_byte == 8'(item_reg.slot))
                                                ? ST_RCVD : waited_reg;
                        end
                    end
                    OP_QUERY: begin
                        res_next.slot_state = waited_st;
                    end
                    default: begin
                    end
                endcase
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            last_reg  <= '0;
        end else begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        res_reg    <= res_next;
        ptr_reg    <= ptr_next;
        cnt_reg    <= cnt_next;
        phase_reg  <= phase_next;
        waited_reg <= waited_next;
    end

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

endmodule

### rtl/core/frame_buffer_slot_table.sv
// Top level of the frame buffer slot table: config register, output register.
//
//  channel  dir  handshake               beat
//  s_       in   s_valid / s_ready       fbst_in_t operation
//  m_       out  m_valid / m_ready       fbst_out_t result
//  cfg_     in   cfg_valid / cfg_ready   port_open bit
//
// Receive makes a second memory pass if the frame passes; allocate reads one slot
// at a time over the status memory read port and visits up to SLOTS-1 slots.
// Reset clears every slot to empty at once through valid bits, no sweep.
// A stalled m_ holds one result; the sequencer waits behind it.
`timescale 1ns / 1ps

module frame_buffer_slot_table
    import fbst_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  fbst_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output fbst_out_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic      cfg_port_open
);

    fbst_ram_req_t ram_req;
    logic [2:0]    ram_rd_data;
    logic          res_valid;
    logic          res_ready;
    fbst_out_t     res;
    logic          port_open_reg;
    logic          m_valid_reg;
    fbst_out_t     m_data_reg;

    fbst_status_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (ram_rd_data)
    );

    fbst_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_valid),
        .item_ready  (s_ready),
        .item        (s_data),
        .port_open   (port_open_reg),
        .ram_req     (ram_req),
        .ram_rd_data (ram_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_open_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                port_open_reg <= cfg_port_open;
            end
            if (res_ready) begin
                m_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
